[sv/idle_timeout_rx_framer_with_magic_detect_core_assert.svh]
// Assertion macros shared by the idle-timeout receive framer.
`ifndef IDLE_TIMEOUT_RX_FRAMER_WITH_MAGIC_DETECT_CORE_ASSERT_SVH
`define IDLE_TIMEOUT_RX_FRAMER_WITH_MAGIC_DETECT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/itrx_pkg.sv]
// Shared types, constants and the magic sequence table of the receive framer.
package itrx_pkg;

    localparam int DEF_FRAME_DEPTH  = 32;
    localparam int DEF_MAGIC_LENGTH = 10;

    localparam int          PADDR_W          = 3;
    localparam logic [7:0]  RST_IDLE_TIMEOUT = 8'd10;
    localparam logic        REG_IDLE_TIMEOUT = 1'b0;

    localparam logic        ACT_BYTE  = 1'b0;
    localparam logic        ACT_TICK  = 1'b1;
    localparam logic        KIND_FRAME = 1'b0;
    localparam logic        KIND_BOOT  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic byte_en;
        logic tick_en;
        logic rd_clear;
        logic rd_issue;
        logic emit;
        logic clear_fill;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic expire;
        logic rd_last;
        logic out_free;
        logic fill_empty;
    } t_stat;

    function automatic logic [7:0] magic_byte(input logic [3:0] pos);
        logic [7:0] v;
        unique case (pos)
            4'd0:    v = 8'h12;
            4'd1:    v = 8'h34;
            4'd2:    v = 8'h56;
            4'd3:    v = 8'h78;
            4'd4:    v = 8'h90;
            4'd5:    v = 8'h90;
            4'd6:    v = 8'h78;
            4'd7:    v = 8'h56;
            4'd8:    v = 8'h34;
            4'd9:    v = 8'h12;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[sv/idle_timeout_rx_framer_with_magic_detect_core.sv]
// Top level of the idle-timeout serial receive framer with boot-sequence detection.
// The input channel (i_in_valid / o_in_stall) carries one transaction per received byte
// or poll tick. A byte that is not flagged overrun is stored in the frame buffer while
// there is room, reloads the idle countdown and advances the magic-sequence matcher.
// A complete magic sequence produces one boot result (kind 1, last 1).
// A tick decrements a nonzero countdown; when it reaches zero with bytes buffered, the
// frame is streamed out on the output channel (o_out_valid / i_out_stall), one byte per
// transaction, last set on the final byte, and the buffer empties.
// A boot result shows up in the output register on the next cycle after its byte is taken.
// While a frame is released after the expiring tick, each byte needs a read on the single
// read port of the frame RAM followed by a load of the output register.
// No input is accepted during a release or while a result waits in a stalled output
// register; a stalled result holds its value. Reset clears the fill count, countdown,
// matcher and output valid, and sets the idle timeout register to 10 ticks. The frame
// RAM needs no clearing, since only written entries are ever read.
// The timeout register sits at APB address 0; pready is always high.
`include "idle_timeout_rx_framer_with_magic_detect_core_assert.svh"

module idle_timeout_rx_framer_with_magic_detect_core import itrx_pkg::*; #(
    parameter int FRAME_DEPTH  = DEF_FRAME_DEPTH,
    parameter int MAGIC_LENGTH = DEF_MAGIC_LENGTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_overrun,
    // Output channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_kind,
    output logic [7:0]         o_frame_byte,
    output logic [5:0]         o_frame_length,
    output logic               o_last,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] r_idle_timeout;
    logic       w_cfg_sel;
    t_cmd       w_cmd;
    t_stat      w_stat;

    // Registers are word aligned; the index is the address above the byte offset.
    assign w_cfg_sel = paddr[PADDR_W-1:2] == REG_IDLE_TIMEOUT;
    assign pready    = 1'b1;
    assign prdata    = w_cfg_sel ? {24'd0, r_idle_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= RST_IDLE_TIMEOUT;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_idle_timeout <= pwdata[7:0];
        end
    end

    itrx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_overrun  (i_overrun),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    itrx_dp #(
        .FRAME_DEPTH  (FRAME_DEPTH),
        .MAGIC_LENGTH (MAGIC_LENGTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_idle_timeout (r_idle_timeout),
        .i_rx_byte      (i_rx_byte),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_frame_byte   (o_frame_byte),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

    // A frame byte is only loaded when the output register can take it.
    `ASSERT_IMPLY(a_emit_slot, i_clk, i_rst_n, w_cmd.emit, w_stat.out_free)
    // Emitting the final byte of a frame leaves the buffer empty.
    `ASSERT_NEXT(a_fill_cleared, i_clk, i_rst_n, w_cmd.emit && w_stat.rd_last, w_stat.fill_empty)
    // A RAM read is always followed by an emit cycle with the input held off.
    `ASSERT_NEXT(a_read_then_emit, i_clk, i_rst_n, w_cmd.rd_issue, !w_cmd.rd_issue && o_in_stall)

endmodule

[sv/itrx_ram.sv]
// Generic single-port-write, registered-read RAM.
module itrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/itrx_dp.sv]
// Datapath of the receive framer: frame buffer, countdown, magic matcher, output register.
module itrx_dp import itrx_pkg::*; #(
    parameter int FRAME_DEPTH  = DEF_FRAME_DEPTH,
    parameter int MAGIC_LENGTH = DEF_MAGIC_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic [7:0] i_idle_timeout,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic       o_kind,
    output logic [7:0] o_frame_byte,
    output logic [5:0] o_frame_length,
    output logic       o_last
);

    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int AW  = $clog2(FRAME_DEPTH);

    logic [FCW-1:0] r_fill, n_fill;
    logic [FCW-1:0] r_rd_idx, n_rd_idx;
    logic [7:0]     r_count, n_count;
    logic [3:0]     r_match, n_match;
    logic           r_out_valid, n_out_valid;
    logic           r_kind;
    logic [7:0]     r_frame_byte;
    logic [5:0]     r_frame_length;
    logic           r_last;

    logic           w_has_room;
    logic           w_hit;
    logic [3:0]     w_match_inc;
    logic           w_boot;
    logic [FCW-1:0] w_rd_next;
    logic [6:0]     w_fill_ext;
    logic [7:0]     w_rdata;
    logic           w_out_free;

    assign w_has_room  = r_fill < FCW'(FRAME_DEPTH);
    assign w_hit       = magic_byte(r_match) == i_rx_byte;
    assign w_match_inc = r_match + 4'd1;
    assign w_boot      = i_cmd.byte_en && w_hit
                         && (w_match_inc == 4'd0 || {1'b0, w_match_inc} >= 5'(MAGIC_LENGTH));
    assign w_rd_next   = r_rd_idx + FCW'(1);
    assign w_fill_ext  = 7'(r_fill);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    itrx_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.byte_en && w_has_room),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_count     = r_count;
        n_match     = r_match;
        n_out_valid = r_out_valid;
        if (i_cmd.byte_en) begin
            if (w_has_room) begin
                n_fill = r_fill + FCW'(1);
            end
            n_count = i_idle_timeout;
            n_match = (w_hit && !w_boot) ? w_match_inc : 4'd0;
        end
        if (i_cmd.tick_en && r_count != 8'd0) begin
            n_count = r_count - 8'd1;
        end
        if (i_cmd.clear_fill) begin
            n_fill = '0;
        end
        if (i_cmd.rd_clear) begin
            n_rd_idx = '0;
        end else if (i_cmd.emit) begin
            n_rd_idx = w_rd_next;
        end
        if (w_boot || i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_count     <= '0;
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_rd_idx    <= n_rd_idx;
            r_count     <= n_count;
            r_match     <= n_match;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_boot) begin
            r_kind         <= KIND_BOOT;
            r_frame_byte   <= 8'd0;
            r_frame_length <= 6'd0;
            r_last         <= 1'b1;
        end else if (i_cmd.emit) begin
            r_kind         <= KIND_FRAME;
            r_frame_byte   <= w_rdata;
            r_frame_length <= w_fill_ext[5:0];
            r_last         <= w_rd_next == r_fill;
        end
    end

    assign o_stat.expire     = (r_count == 8'd1) && (r_fill != '0);
    assign o_stat.rd_last    = w_rd_next == r_fill;
    assign o_stat.out_free   = w_out_free;
    assign o_stat.fill_empty = r_fill == '0;

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_frame_byte   = r_frame_byte;
    assign o_frame_length = r_frame_length;
    assign o_last         = r_last;

endmodule

[sv/itrx_ctrl.sv]
// Controller of the receive framer: input handshake and frame release sequencer.
module itrx_ctrl import itrx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_action,
    input  logic  i_overrun,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE) || !i_stat.out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.byte_en    = w_accept && i_action == ACT_BYTE && !i_overrun;
        o_cmd.tick_en    = w_accept && i_action == ACT_TICK;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.tick_en && i_stat.expire) begin
                    o_cmd.rd_clear = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.rd_last) begin
                        o_cmd.clear_fill = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
